/* hw/rtl/vha_pkg.sv */
package vha_pkg;

    // Grid store size and derived address widths
    localparam int NUM_VOXELS = 16384;
    localparam int ADDR_W     = (NUM_VOXELS > 1) ? $clog2(NUM_VOXELS) : 1;
    localparam int VN_W       = 49;
    localparam logic [VN_W-1:0] NUM_VOXELS_VN = VN_W'(NUM_VOXELS);

    // Field widths
    localparam int CMD_W     = 2;
    localparam int POS_W     = 16;
    localparam int WGT_W     = 24;
    localparam int VN_OUT_W  = 14;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 48;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W    = CNT_W + SUM_W + SUM_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXT_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd5;

    // Reset configuration and the grid it implies
    localparam int EXT_X_RST  = 500;
    localparam int EXT_Y_RST  = 500;
    localparam int EXT_Z_RST  = 400;
    localparam int SIZE_X_RST = 10;
    localparam int SIZE_Y_RST = 10;
    localparam int SIZE_Z_RST = 80;
    localparam int NX_RST     = EXT_X_RST / SIZE_X_RST;
    localparam int NY_RST     = EXT_Y_RST / SIZE_Y_RST;
    localparam int NZ_RST     = EXT_Z_RST / SIZE_Z_RST;
    localparam int NXY_RST    = NX_RST * NY_RST;
    localparam int TOTAL_RST  = NXY_RST * NZ_RST;

    // Divider geometry
    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 32;
    localparam int DIV_S_W = 6;
    localparam logic [DIV_S_W-1:0] GRID_STEPS = 6'd16;
    localparam logic [DIV_S_W-1:0] AXIS_STEPS = 6'd17;
    localparam logic [DIV_S_W-1:0] AVG_STEPS  = 6'd48;

    // Average saturation limits
    localparam logic [DIV_N_W-1:0] AVG_LIM     = 48'h80_0000;
    localparam logic [WGT_W-1:0]   AVG_POS_MAX = 24'h7F_FFFF;
    localparam logic [WGT_W-1:0]   AVG_NEG_MIN = 24'h80_0000;

    // Front/back queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_READ,
        OP_CLEAR,
        OP_ZERO
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic                 in_range;
        logic [VN_OUT_W-1:0]  vn;
        logic [ADDR_W-1:0]    addr;
        logic [WGT_W-1:0]     weight;
    } qent_t;

    typedef struct packed {
        logic init_busy;
    } back_stat_t;

    typedef struct packed {
        logic                start;
        logic [DIV_S_W-1:0]  steps;
        logic [DIV_N_W-1:0]  dividend;
        logic [DIV_D_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                in_range;
        logic [VN_OUT_W-1:0] vn;
        logic [CNT_W-1:0]    cnt;
        logic [SUM_W-1:0]    ssum;
        logic [SUM_W-1:0]    msum;
        logic [WGT_W-1:0]    avg;
    } res_t;

endpackage

/* hw/rtl/vha_ram.sv */
module vha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/vha_div.sv */
module vha_div import vha_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_S_W-1:0]   cnt_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;
    logic                 ge;
    logic [DIV_D_W-1:0]   rem_next;
    logic [DIV_S_W-1:0]   shamt;

    // One restoring step: bring down the next dividend bit
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_N_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
        shamt    = DIV_S_W'(DIV_N_W) - req.steps;
    end

    // Control: count steps, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_S_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: align dividend so only the requested steps are run
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend << shamt;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/vha_queue.sv */
module vha_queue import vha_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  qent_t wdata,
    output logic  full,
    input  logic  rd,
    output qent_t rdata,
    output logic  empty
);

    qent_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = slot_reg[rptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

/* hw/rtl/vha_front.sv */
module vha_front import vha_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [CMD_W-1:0]        command,
    input  logic [POS_W-1:0]        pos_x,
    input  logic [POS_W-1:0]        pos_y,
    input  logic [POS_W-1:0]        pos_z,
    input  logic [WGT_W-1:0]        weight,
    input  logic [VN_OUT_W-1:0]     read_index,
    output logic                    q_push,
    output qent_t                   q_data,
    input  logic                    q_full,
    input  back_stat_t              bstat
);

    typedef enum logic [7:0] {
        F_IDLE  = 8'b0000_0001,
        F_GDIV  = 8'b0000_0010,
        F_GMUL1 = 8'b0000_0100,
        F_GMUL2 = 8'b0000_1000,
        F_DIV   = 8'b0001_0000,
        F_MUL   = 8'b0010_0000,
        F_SUM   = 8'b0100_0000,
        F_PUSH  = 8'b1000_0000
    } front_state_t;

    front_state_t        state_reg;
    front_state_t        state_next;
    logic [CFG_W-1:0]    ext_reg    [3];
    logic [CFG_W-1:0]    size_reg   [3];
    logic [CFG_W-1:0]    grid_n_reg [3];
    logic                grid_pend_reg;
    logic [31:0]         nxy_reg;
    logic [47:0]         total_reg;
    logic [WGT_W-1:0]    weight_reg;
    logic                axis_ok_reg [3];
    logic [POS_W-1:0]    idx_reg    [3];
    logic                inb_reg;
    logic [47:0]         t1_reg;
    logic [31:0]         t2_reg;
    qent_t               ent_reg;

    logic [POS_W-1:0]    pos_a   [3];
    logic [17:0]         num_a   [3];
    logic                inb_a   [3];
    div_req_t            div_req [3];
    logic                div_done [3];
    logic [DIV_N_W-1:0]  div_quo [3];
    logic                accept;
    logic [VN_W-1:0]     idx_vn;
    logic                rd_ok;
    logic [VN_W-1:0]     vn_sum;
    logic                ins_ok;
    qent_t               cmd_ent;
    qent_t               ins_ent;

    assign pos_a[0] = pos_x;
    assign pos_a[1] = pos_y;
    assign pos_a[2] = pos_z;

    assign full   = (state_reg != F_IDLE) || grid_pend_reg || q_full || bstat.init_busy;
    assign accept = push && !full;

    // Offset coordinates, drive the three axis dividers
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            num_a[a] = {pos_a[a][POS_W-1], pos_a[a], 1'b0} + {2'b00, ext_reg[a]};
            inb_a[a] = axis_ok_reg[a] && (div_quo[a] < {32'b0, grid_n_reg[a]});
            div_req[a].start = (state_reg == F_IDLE)
                && (grid_pend_reg || (accept && (command == CMD_INSERT)));
            if (grid_pend_reg)
            begin
                div_req[a].steps    = GRID_STEPS;
                div_req[a].dividend = {32'b0, ext_reg[a]};
                div_req[a].divisor  = {16'b0, size_reg[a]};
            end
            else
            begin
                div_req[a].steps    = AXIS_STEPS;
                div_req[a].dividend = {31'b0, num_a[a][16:0]};
                div_req[a].divisor  = {15'b0, size_reg[a], 1'b0};
            end
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        vha_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (div_req[g]),
            .done     (div_done[g]),
            .quotient (div_quo[g])
        );
    end

    // Classify reads, clears and unused codes
    always_comb
    begin
        idx_vn           = VN_W'(read_index);
        rd_ok            = (idx_vn < {1'b0, total_reg}) && (idx_vn < NUM_VOXELS_VN);
        cmd_ent.weight   = weight;
        cmd_ent.vn       = '0;
        cmd_ent.addr     = idx_vn[ADDR_W-1:0];
        cmd_ent.in_range = 1'b0;
        case (command)
            CMD_READ:
            begin
                cmd_ent.op       = rd_ok ? OP_READ : OP_ZERO;
                cmd_ent.in_range = rd_ok;
                cmd_ent.vn       = read_index;
            end
            CMD_CLEAR: cmd_ent.op = OP_CLEAR;
            default:   cmd_ent.op = OP_ZERO;
        endcase
    end

    // Form the linear voxel number of an insert
    always_comb
    begin
        vn_sum = {1'b0, t1_reg} + VN_W'(t2_reg) + VN_W'(idx_reg[0]);
        ins_ok = inb_reg && (vn_sum < NUM_VOXELS_VN);
        ins_ent.op       = ins_ok ? OP_INSERT : OP_ZERO;
        ins_ent.in_range = ins_ok;
        ins_ent.vn       = ins_ok ? vn_sum[VN_OUT_W-1:0] : '0;
        ins_ent.addr     = vn_sum[ADDR_W-1:0];
        ins_ent.weight   = weight_reg;
    end

    // Sequence the front
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (grid_pend_reg)
                begin
                    state_next = F_GDIV;
                end
                else if (accept)
                begin
                    state_next = (command == CMD_INSERT) ? F_DIV : F_PUSH;
                end
            end
            F_GDIV:  state_next = div_done[0] ? F_GMUL1 : F_GDIV;
            F_GMUL1: state_next = F_GMUL2;
            F_GMUL2: state_next = F_IDLE;
            F_DIV:   state_next = div_done[0] ? F_MUL : F_DIV;
            F_MUL:   state_next = F_SUM;
            F_SUM:   state_next = F_PUSH;
            F_PUSH:  state_next = q_full ? F_PUSH : F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Control state, configuration and grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            ext_reg[0]    <= CFG_W'(EXT_X_RST);
            ext_reg[1]    <= CFG_W'(EXT_Y_RST);
            ext_reg[2]    <= CFG_W'(EXT_Z_RST);
            size_reg[0]   <= CFG_W'(SIZE_X_RST);
            size_reg[1]   <= CFG_W'(SIZE_Y_RST);
            size_reg[2]   <= CFG_W'(SIZE_Z_RST);
            grid_n_reg[0] <= CFG_W'(NX_RST);
            grid_n_reg[1] <= CFG_W'(NY_RST);
            grid_n_reg[2] <= CFG_W'(NZ_RST);
            nxy_reg       <= 32'(NXY_RST);
            total_reg     <= 48'(TOTAL_RST);
            grid_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_EXT_X:  ext_reg[0]  <= cfg_data;
                    REG_EXT_Y:  ext_reg[1]  <= cfg_data;
                    REG_EXT_Z:  ext_reg[2]  <= cfg_data;
                    REG_SIZE_X: size_reg[0] <= cfg_data;
                    REG_SIZE_Y: size_reg[1] <= cfg_data;
                    REG_SIZE_Z: size_reg[2] <= cfg_data;
                    default:    ;
                endcase
                grid_pend_reg <= 1'b1;
            end
            else if (state_reg == F_IDLE)
            begin
                grid_pend_reg <= 1'b0;
            end
            if ((state_reg == F_GDIV) && div_done[0])
            begin
                for (int a = 0; a < 3; a++)
                begin
                    grid_n_reg[a] <= (size_reg[a] == '0) ? '0 : div_quo[a][CFG_W-1:0];
                end
            end
            if (state_reg == F_GMUL1)
            begin
                nxy_reg <= grid_n_reg[0] * grid_n_reg[1];
            end
            if (state_reg == F_GMUL2)
            begin
                total_reg <= {16'b0, nxy_reg} * {32'b0, grid_n_reg[2]};
            end
        end
    end

    // Item payload through the front
    always_ff @(posedge clk)
    begin
        if ((state_reg == F_IDLE) && accept)
        begin
            weight_reg <= weight;
            for (int a = 0; a < 3; a++)
            begin
                axis_ok_reg[a] <= !num_a[a][17] && (size_reg[a] != '0);
            end
            ent_reg <= cmd_ent;
        end
        if ((state_reg == F_DIV) && div_done[0])
        begin
            for (int a = 0; a < 3; a++)
            begin
                idx_reg[a] <= div_quo[a][POS_W-1:0];
            end
            inb_reg <= inb_a[0] && inb_a[1] && inb_a[2];
        end
        if (state_reg == F_MUL)
        begin
            t1_reg <= {32'b0, idx_reg[2]} * {16'b0, nxy_reg};
            t2_reg <= idx_reg[1] * grid_n_reg[0];
        end
        if (state_reg == F_SUM)
        begin
            ent_reg <= ins_ent;
        end
    end

    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_data = ent_reg;

endmodule

/* hw/rtl/vha_back.sv */
module vha_back import vha_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  qent_t       q_data,
    output logic        q_pop,
    output back_stat_t  bstat,
    output logic        res_valid,
    input  logic        res_pop,
    output res_t        res
);

    typedef enum logic [6:0] {
        B_INIT  = 7'b000_0001,
        B_IDLE  = 7'b000_0010,
        B_READ  = 7'b000_0100,
        B_AVG   = 7'b000_1000,
        B_DIV   = 7'b001_0000,
        B_OUT   = 7'b010_0000,
        B_CLEAR = 7'b100_0000
    } back_state_t;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [ADDR_W-1:0]   sweep_reg;
    qent_t               cur_reg;
    res_t                work_reg;
    res_t                out_reg;
    logic                out_valid_reg;

    logic                sweeping;
    logic                sweep_last;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]    old_c;
    logic [SUM_W-1:0]    old_s;
    logic [SUM_W-1:0]    old_m;
    logic [CNT_W-1:0]    new_c;
    logic [SUM_W-1:0]    new_s;
    logic [SUM_W-1:0]    new_m;
    logic [SUM_W:0]      s_sum;
    logic [SUM_W:0]      m_sum;
    logic [WGT_W-1:0]    abs_w;
    logic                is_ins;
    div_req_t            div_req;
    logic                div_done;
    logic [DIV_N_W-1:0]  div_quo;
    logic [WGT_W-1:0]    avg_sat;
    logic                out_free;

    assign sweeping   = (state_reg == B_INIT) || (state_reg == B_CLEAR);
    assign sweep_last = (sweep_reg == ADDR_W'(NUM_VOXELS - 1));
    assign is_ins     = (cur_reg.op == OP_INSERT);
    assign out_free   = !out_valid_reg || res_pop;

    // Read-modify-write of one voxel word
    always_comb
    begin
        old_c = ram_rdata[WORD_W-1 -: CNT_W];
        old_s = ram_rdata[2*SUM_W-1 -: SUM_W];
        old_m = ram_rdata[SUM_W-1:0];
        abs_w = cur_reg.weight[WGT_W-1] ? (~cur_reg.weight + 1'b1) : cur_reg.weight;
        new_c = (old_c == '1) ? old_c : old_c + 1'b1;
        s_sum = {old_s[SUM_W-1], old_s}
              + {{(SUM_W+1-WGT_W){cur_reg.weight[WGT_W-1]}}, cur_reg.weight};
        if (s_sum[SUM_W] != s_sum[SUM_W-1])
        begin
            new_s = {s_sum[SUM_W], {(SUM_W-1){~s_sum[SUM_W]}}};
        end
        else
        begin
            new_s = s_sum[SUM_W-1:0];
        end
        m_sum = {1'b0, old_m} + {{(SUM_W+1-WGT_W){1'b0}}, abs_w};
        new_m = m_sum[SUM_W] ? '1 : m_sum[SUM_W-1:0];
    end

    assign ram_we    = sweeping || ((state_reg == B_READ) && is_ins);
    assign ram_waddr = sweeping ? sweep_reg : cur_reg.addr;
    assign ram_wdata = sweeping ? '0 : {new_c, new_s, new_m};

    vha_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_VOXELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (q_data.addr),
        .rdata (ram_rdata)
    );

    // Average divider: magnitude of the sum over the count
    always_comb
    begin
        div_req.start    = (state_reg == B_AVG) && (work_reg.cnt != '0);
        div_req.steps    = AVG_STEPS;
        div_req.dividend = work_reg.ssum[SUM_W-1] ? (~work_reg.ssum + 1'b1) : work_reg.ssum;
        div_req.divisor  = work_reg.cnt;
        if (work_reg.ssum[SUM_W-1])
        begin
            avg_sat = (div_quo >= AVG_LIM) ? AVG_NEG_MIN : (~div_quo[WGT_W-1:0] + 1'b1);
        end
        else
        begin
            avg_sat = (div_quo >= AVG_LIM) ? AVG_POS_MAX : div_quo[WGT_W-1:0];
        end
    end

    vha_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    // Sequence the back
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_INIT:  state_next = sweep_last ? B_IDLE : B_INIT;
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_data.op)
                        OP_INSERT: state_next = B_READ;
                        OP_READ:   state_next = B_READ;
                        OP_CLEAR:  state_next = B_CLEAR;
                        default:   state_next = B_OUT;
                    endcase
                end
            end
            B_READ:  state_next = B_AVG;
            B_AVG:   state_next = (work_reg.cnt != '0) ? B_DIV : B_OUT;
            B_DIV:   state_next = div_done ? B_OUT : B_DIV;
            B_OUT:   state_next = out_free ? B_IDLE : B_OUT;
            B_CLEAR: state_next = sweep_last ? B_OUT : B_CLEAR;
            default: state_next = B_IDLE;
        endcase
    end

    // Control state: sweep address and result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (sweeping)
            begin
                sweep_reg <= sweep_last ? '0 : sweep_reg + 1'b1;
            end
            if ((state_reg == B_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working result and output beat
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg       <= q_data;
            work_reg      <= '0;
            work_reg.vn   <= (q_data.op == OP_ZERO) ? q_data.vn : '0;
        end
        if (state_reg == B_READ)
        begin
            work_reg.in_range <= cur_reg.in_range;
            work_reg.vn       <= cur_reg.vn;
            work_reg.cnt      <= is_ins ? new_c : old_c;
            work_reg.ssum     <= is_ins ? new_s : old_s;
            work_reg.msum     <= is_ins ? new_m : old_m;
            work_reg.avg      <= '0;
        end
        if ((state_reg == B_DIV) && div_done)
        begin
            work_reg.avg <= avg_sat;
        end
        if ((state_reg == B_OUT) && out_free)
        begin
            out_reg <= work_reg;
        end
    end

    assign bstat.init_busy = (state_reg == B_INIT);
    assign res_valid       = out_valid_reg;
    assign res             = out_reg;

endmodule

/* hw/rtl/voxel_histogram_accumulator_core.sv */
// Channel   Handshake            Payload
// ------    -------------------  ----------------------------------------------
// input     push / full          command, pos_x/y/z, weight, read_index
// result    empty / pop          in_range, voxel_number, hit_count, signed_sum,
//                                magnitude_sum, average_weight
// config    cfg_write            cfg_index, cfg_data (no wait, no read-back)
//
// An insert passes the front through the 17-step axis dividers and the multiply
// and sum states, then the back, where the 48-step average divider limits the
// sustained rate of in-range inserts and of reads of voxels with hits.
// A clear sweeps the voxel memory one entry a cycle.
// After reset the same sweep runs with full held high.
// A config write recomputes the grid with full high.
// A result waiting on pop stalls the next item in the back's output state until it is popped.
module voxel_histogram_accumulator_core import vha_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [CMD_W-1:0]            command,
    input  logic signed [POS_W-1:0]     pos_x,
    input  logic signed [POS_W-1:0]     pos_y,
    input  logic signed [POS_W-1:0]     pos_z,
    input  logic signed [WGT_W-1:0]     weight,
    input  logic [VN_OUT_W-1:0]         read_index,
    output logic                        empty,
    input  logic                        pop,
    output logic                        in_range,
    output logic [VN_OUT_W-1:0]         voxel_number,
    output logic [CNT_W-1:0]            hit_count,
    output logic signed [SUM_W-1:0]     signed_sum,
    output logic [SUM_W-1:0]            magnitude_sum,
    output logic signed [WGT_W-1:0]     average_weight
);

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    qent_t       q_wdata;
    qent_t       q_rdata;
    back_stat_t  bstat;
    logic        res_valid;
    res_t        res;

    // Accept and classify items
    vha_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .command    (command),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .weight     (weight),
        .read_index (read_index),
        .q_push     (q_push),
        .q_data     (q_wdata),
        .q_full     (q_full),
        .bstat      (bstat)
    );

    // Decouple front from back
    vha_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Carry out commands against the voxel memory
    vha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .bstat     (bstat),
        .res_valid (res_valid),
        .res_pop   (pop),
        .res       (res)
    );

    assign empty          = !res_valid;
    assign in_range       = res.in_range;
    assign voxel_number   = res.vn;
    assign hit_count      = res.cnt;
    assign signed_sum     = res.ssum;
    assign magnitude_sum  = res.msum;
    assign average_weight = res.avg;

endmodule

/* test/tb_voxel_histogram_accumulator_core.sv */
module tb_voxel_histogram_accumulator_core;
    import vha_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam longint MAG_HI = 64'sh0000_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 150;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic push;
    logic full;
    logic [CMD_W-1:0] command;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [WGT_W-1:0] weight;
    logic [VN_OUT_W-1:0] read_index;
    logic empty;
    logic pop;
    logic in_range;
    logic [VN_OUT_W-1:0] voxel_number;
    logic [CNT_W-1:0] hit_count;
    logic signed [SUM_W-1:0] signed_sum;
    logic [SUM_W-1:0] magnitude_sum;
    logic signed [WGT_W-1:0] average_weight;

    // Mirror of the voxel stores and grid setup
    int unsigned hit_mem [NUM_VOXELS];
    longint ssum_mem [NUM_VOXELS];
    longint msum_mem [NUM_VOXELS];
    longint extent [3];
    longint vsize [3];
    longint ncells [3];

    res_t pending_beats [$];
    bit failed;
    bit gaps_on;
    int hold_left;
    int stall_left;
    int cycle_count;
    int last_voxel;
    int clears_left;

    voxel_histogram_accumulator_core uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[voxel_histogram_accumulator_core] ERROR");
            $finish;
        end
    end

    task automatic zero_stores();
        for (int i = 0; i < NUM_VOXELS; i++)
        begin
            hit_mem[i] = 0;
            ssum_mem[i] = 0;
            msum_mem[i] = 0;
        end
    endtask

    task automatic refresh_grid();
        for (int a = 0; a < 3; a++)
            ncells[a] = (vsize[a] == 0) ? 0 : extent[a] / vsize[a];
    endtask

    // Axis bin; -1 when outside the grid
    function automatic longint axis_bin(logic signed [POS_W-1:0] p, int a);
        longint num;
        longint q;
        num = 2 * longint'(p) + extent[a];
        if (num < 0 || vsize[a] == 0)
            return -1;
        q = num / (2 * vsize[a]);
        return (q >= ncells[a]) ? -1 : q;
    endfunction

    function automatic res_t voxel_beat(int vn);
        res_t r;
        longint avg;
        avg = 0;
        if (hit_mem[vn] != 0)
        begin
            avg = ssum_mem[vn] / longint'(hit_mem[vn]);
            if (avg > 8388607) avg = 8388607;
            if (avg < -8388608) avg = -8388608;
        end
        r.in_range = 1'b1;
        r.vn = VN_OUT_W'(vn);
        r.cnt = hit_mem[vn];
        r.ssum = SUM_W'(ssum_mem[vn]);
        r.msum = SUM_W'(msum_mem[vn]);
        r.avg = WGT_W'(avg);
        return r;
    endfunction

    // Apply one command to the mirror and return the beat it yields
    task automatic bin_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [POS_W-1:0] px,
                               input logic signed [POS_W-1:0] py,
                               input logic signed [POS_W-1:0] pz,
                               input logic signed [WGT_W-1:0] w,
                               input logic [VN_OUT_W-1:0] ridx,
                               output res_t r);
        longint ix, iy, iz, vn, s, m;
        r = '0;
        if (cmd == CMD_INSERT)
        begin
            ix = axis_bin(px, 0);
            iy = axis_bin(py, 1);
            iz = axis_bin(pz, 2);
            if (ix < 0 || iy < 0 || iz < 0)
                return;
            vn = iz * ncells[0] * ncells[1] + iy * ncells[0] + ix;
            if (vn >= NUM_VOXELS)
                return;
            if (hit_mem[vn] != 32'hFFFF_FFFF)
                hit_mem[vn]++;
            s = ssum_mem[vn] + longint'(w);
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            ssum_mem[vn] = s;
            m = msum_mem[vn] + ((w < 0) ? -longint'(w) : longint'(w));
            if (m > MAG_HI) m = MAG_HI;
            msum_mem[vn] = m;
            r = voxel_beat(int'(vn));
        end
        else if (cmd == CMD_READ)
        begin
            if (longint'(ridx) >= ncells[0] * ncells[1] * ncells[2])
                r.vn = ridx;
            else
                r = voxel_beat(int'(ridx));
        end
        else if (cmd == CMD_CLEAR)
        begin
            zero_stores();
        end
    endtask

    // Offer one item and hold it until accepted; push stays high afterwards
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py,
                             input logic signed [POS_W-1:0] pz,
                             input logic signed [WGT_W-1:0] w,
                             input logic [VN_OUT_W-1:0] ridx);
        res_t r;
        push <= 1'b1;
        command <= cmd;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        weight <= w;
        read_index <= ridx;
        do @(posedge clk); while (full);
        bin_command(cmd, px, py, pz, w, ridx, r);
        pending_beats.push_back(r);
        if (cmd == CMD_INSERT && r.in_range)
            last_voxel = r.vn;
    endtask

    task automatic pause_input(int n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Random sender gap between items
    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 7) == 0)
            pause_input($urandom_range(1, 13));
    endtask

    // Wait for every expected beat, then let the pipeline go quiet
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_grid(int ex, int ey, int ez, int sx, int sy, int sz);
        int vals [6];
        logic [CFG_IDX_W-1:0] regs [6];
        vals = '{ex, ey, ez, sx, sy, sz};
        regs = '{REG_EXT_X, REG_EXT_Y, REG_EXT_Z, REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};
        drain();
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= CFG_W'(vals[i]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            extent[a] = vals[a] & 16'hFFFF;
            vsize[a] = vals[a + 3] & 16'hFFFF;
        end
        refresh_grid();
        repeat (3) @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] pos_inside(int a);
        int span;
        span = (extent[a] > 0) ? int'(extent[a]) : 1;
        return POS_W'($urandom_range(0, span - 1) - span / 2);
    endfunction

    // Check each beat taken at the output, then pick the next pop value
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && pop && !empty)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected result beat, voxel_number %0d", voxel_number);
                failed <= 1'b1;
            end
            else
            begin
                e = pending_beats.pop_front();
                if (in_range !== e.in_range)
                begin
                    $error("in_range: expected %0d, got %0d", e.in_range, in_range);
                    failed <= 1'b1;
                end
                if (voxel_number !== e.vn)
                begin
                    $error("voxel_number: expected %0d, got %0d", e.vn, voxel_number);
                    failed <= 1'b1;
                end
                if (hit_count !== e.cnt)
                begin
                    $error("hit_count: expected %0d, got %0d", e.cnt, hit_count);
                    failed <= 1'b1;
                end
                if (signed_sum !== e.ssum)
                begin
                    $error("signed_sum: expected %0d, got %0d",
                           $signed(e.ssum), signed_sum);
                    failed <= 1'b1;
                end
                if (magnitude_sum !== e.msum)
                begin
                    $error("magnitude_sum: expected %0d, got %0d", e.msum, magnitude_sum);
                    failed <= 1'b1;
                end
                if (average_weight !== e.avg)
                begin
                    $error("average_weight: expected %0d, got %0d",
                           $signed(e.avg), average_weight);
                    failed <= 1'b1;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 12);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // Reset grid: corners, edges, extreme weights, reads, unused code, clear
    task automatic test_reset_grid();
        send_item(CMD_INSERT, 0, 0, 0, 24'sd1000, 0);
        send_item(CMD_INSERT, 0, 0, 0, -24'sd3001, 0);
        send_item(CMD_INSERT, -250, -250, -200, 24'sh7FFFFF, 0);
        send_item(CMD_INSERT, -250, -250, -200, 24'sh800000, 0);
        send_item(CMD_INSERT, 249, 249, 199, 24'sh800000, 0);
        send_item(CMD_INSERT, 250, 0, 0, 24'sd5, 0);
        send_item(CMD_INSERT, 0, -251, 0, 24'sd5, 0);
        send_item(CMD_INSERT, 0, 0, 200, 24'sd5, 0);
        send_item(CMD_INSERT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 24'sh7FFFFF, 14'h3FFF);
        send_item(CMD_INSERT, 16'sh8000, 16'sh8000, 16'sh8000, 24'sd0, 0);
        maybe_gap();
        send_item(CMD_READ, 0, 0, 0, 0, 14'd0);
        send_item(CMD_READ, 0, 0, 0, 0, 14'd12499);
        send_item(CMD_READ, 0, 0, 0, 0, 14'd12500);
        send_item(CMD_READ, 16'sh7FFF, 16'sh8000, -1, 24'sh7FFFFF, 14'h3FFF);
        send_item(CMD_READ, 0, 0, 0, 0, VN_OUT_W'(last_voxel));
        send_item(CMD_UNUSED, -1, -1, -1, -24'sd1, 14'h3FFF);
        send_item(CMD_UNUSED, 0, 0, 0, 0, 0);
        send_item(CMD_CLEAR, 5, 5, 5, 24'sd7, 14'h2AAA);
        send_item(CMD_READ, 0, 0, 0, 0, 14'd0);
        send_item(CMD_READ, 0, 0, 0, 0, VN_OUT_W'(last_voxel));
    endtask

    // Odd extent: half-millimeter edges bin exactly
    task automatic test_odd_extent();
        set_grid(41, 41, 41, 10, 10, 10);
        send_item(CMD_INSERT, -20, -20, -20, 24'sd9, 0);
        send_item(CMD_INSERT, 20, 0, 0, 24'sd9, 0);
        send_item(CMD_INSERT, 19, 19, 19, -24'sd9, 0);
        send_item(CMD_INSERT, -21, 0, 0, 24'sd9, 0);
        send_item(CMD_READ, 0, 0, 0, 0, 14'd63);
        send_item(CMD_READ, 0, 0, 0, 0, 14'd64);
    endtask

    // Zero sizes and zero extents leave an empty grid
    task automatic test_empty_grid();
        set_grid(500, 500, 400, 0, 0, 0);
        send_item(CMD_INSERT, 0, 0, 0, 24'sd1, 0);
        send_item(CMD_READ, 0, 0, 0, 0, 14'd0);
        set_grid(0, 0, 0, 10, 10, 10);
        send_item(CMD_INSERT, 0, 0, 0, 24'sd1, 0);
        send_item(CMD_READ, 0, 0, 0, 0, 14'd5);
    endtask

    // Largest grid overflows the store; a one-voxel grid takes everything
    task automatic test_wide_grid();
        set_grid(65535, 65535, 65535, 1, 1, 1);
        send_item(CMD_INSERT, -32767, -32767, -32767, 24'sd3, 0);
        send_item(CMD_INSERT, 16'sh8000, -32767, -32767, 24'sd3, 0);
        send_item(CMD_INSERT, -16000, -32767, -32767, 24'sd3, 0);
        send_item(CMD_INSERT, -32767, -32766, -32767, 24'sd3, 0);
        send_item(CMD_INSERT, 32767, 32767, 32767, 24'sd3, 0);
        send_item(CMD_READ, 0, 0, 0, 0, 14'h3FFF);
        set_grid(65535, 65535, 65535, 65535, 65535, 65535);
        for (int i = 0; i < 6; i++)
            send_item(CMD_INSERT, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                      WGT_W'($urandom), 0);
        send_item(CMD_READ, 0, 0, 0, 0, 14'd0);
        send_item(CMD_READ, 0, 0, 0, 0, 14'd1);
    endtask

    // Hold the output off long enough to back the input up
    task automatic test_backpressure();
        set_grid(40, 40, 40, 10, 10, 10);
        hold_left = 600;
        for (int i = 0; i < 12; i++)
            send_item(CMD_INSERT, pos_inside(0), pos_inside(1), pos_inside(2),
                      WGT_W'($urandom), 0);
    endtask

    task automatic random_item();
        int pick;
        longint total;
        pick = $urandom_range(0, 99);
        total = ncells[0] * ncells[1] * ncells[2];
        if (total > NUM_VOXELS) total = NUM_VOXELS;
        if (pick < 55)
            send_item(CMD_INSERT, pos_inside(0), pos_inside(1), pos_inside(2),
                      WGT_W'($urandom), VN_OUT_W'($urandom));
        else if (pick < 70)
            send_item(CMD_READ, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                      WGT_W'($urandom), VN_OUT_W'(last_voxel));
        else if (pick < 82 && total > 0)
            send_item(CMD_READ, 0, 0, 0, 0, VN_OUT_W'($urandom_range(0, int'(total) - 1)));
        else if (pick == 99 && clears_left > 0)
        begin
            clears_left--;
            send_item(CMD_CLEAR, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                      WGT_W'($urandom), VN_OUT_W'($urandom));
        end
        else
            send_item(CMD_UNUSED & CMD_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                      POS_W'($urandom), WGT_W'($urandom), VN_OUT_W'($urandom));
        maybe_gap();
    endtask

    // Random grids, mostly small so voxels get hit repeatedly
    task automatic test_random_grids();
        int n [3];
        int sz [3];
        for (int phase = 0; phase < 5; phase++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                n[a] = $urandom_range(1, 12);
                sz[a] = $urandom_range(1, 2000);
            end
            if (phase == 4)
                set_grid($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(1, 65535),
                         $urandom_range(1, 65535), $urandom_range(1, 65535));
            else
                set_grid(n[0] * sz[0] + $urandom_range(0, sz[0] - 1),
                         n[1] * sz[1] + $urandom_range(0, sz[1] - 1),
                         n[2] * sz[2] + $urandom_range(0, sz[2] - 1), sz[0], sz[1], sz[2]);
            gaps_on = (phase != 2);
            for (int i = 0; i < 220; i++)
                random_item();
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_tail();
        set_grid(60, 60, 30, 10, 10, 10);
        gaps_on = 1'b0;
        for (int i = 0; i < 100; i++)
            random_item();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_EXT_X;
        cfg_data <= '0;
        push <= 1'b0;
        command <= CMD_INSERT;
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
        weight <= '0;
        read_index <= '0;
        failed = 1'b0;
        gaps_on = 1'b1;
        hold_left = 0;
        stall_left = 0;
        cycle_count = 0;
        last_voxel = 0;
        clears_left = 2;
        extent = '{EXT_X_RST, EXT_Y_RST, EXT_Z_RST};
        vsize = '{SIZE_X_RST, SIZE_Y_RST, SIZE_Z_RST};
        refresh_grid();
        zero_stores();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_grid();
        test_odd_extent();
        test_empty_grid();
        test_wide_grid();
        test_backpressure();
        test_random_grids();
        test_tail();
        drain();

        if (!failed)
            $display("[voxel_histogram_accumulator_core] OK");
        else
            $display("[voxel_histogram_accumulator_core] ERROR");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/vha_pkg.sv
hw/rtl/vha_ram.sv
hw/rtl/vha_div.sv
hw/rtl/vha_queue.sv
hw/rtl/vha_front.sv
hw/rtl/vha_back.sv
hw/rtl/voxel_histogram_accumulator_core.sv
test/tb_voxel_histogram_accumulator_core.sv
